@@ sv/rbc_pkg.sv @@
// rbc_pkg: shared types and constants for the run-length byte compressor.
// Used by rbc_ctrl, rbc_dpath and rle_byte_compressor; depends on nothing.
`timescale 1ns / 1ps

package rbc_pkg;

  localparam int BYTE_W          = 8;
  localparam int RC_W            = 8;    // repeat count, holds up to 128
  localparam int MAX_LITERAL_DEF = 32;
  localparam int MAX_REPEAT_DEF  = 128;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_EOS_CHK,
    S_LIT_HDR,
    S_LIT_DATA,
    S_RUN_HDR,
    S_RUN_BYTE
  } state_t;

  typedef enum logic [1:0] {
    SEL_LIT_HDR,
    SEL_RUN_HDR,
    SEL_LIT_DATA,
    SEL_HELD
  } emit_sel_t;

  typedef struct packed {
    logic      latch_in;     // capture the accepted input beat
    logic      first_load;   // nothing held: start with this byte
    logic      set_rc2;      // pair met: run of two
    logic      inc_rc;
    logic      push;         // append held byte to literal buffer
    logic      load_new;     // held <= input byte, count 1
    logic      clear_all;    // end of stream: back to idle
    logic      lit_advance;  // next literal read address
    logic      lit_done;     // literal buffer drained
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic have_held;
    logic eq;          // input byte equals held byte
    logic rc_is1;
    logic rc_ge2;
    logic rc_at_max;
    logic lit_nz;
    logic lit_will_fill;
    logic lit_last;    // read pointer on last pending literal
    logic eos;
    logic out_free;
  } ctrl_status_t;

endpackage

@@ sv/rle_byte_compressor.sv @@
// rle_byte_compressor: top level of the PackBits-style byte compressor.
// Depends on rbc_pkg, rbc_ctrl, rbc_dpath (which holds rbc_ram).
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid/in_ready   | data_in[7:0], end_of_stream
//   output  | out       | out_valid/out_ready | code_byte[7:0], is_header, last_of_run
//
// One input beat at a time: S_EVAL handles each byte, then every result byte
// is emitted in turn, and end_of_stream adds an S_EOS_CHK step that drains state.
// The controller's sequencing of one emission per cycle into the single
// output register sets the rate; a stalled output holds the sequence.
// The next input beat is taken while the last result still waits in the
// output register. Reset (rst, synchronous) clears all control state.
`timescale 1ns / 1ps

module rle_byte_compressor #(
  parameter int MAX_LITERAL = rbc_pkg::MAX_LITERAL_DEF,
  parameter int MAX_REPEAT  = rbc_pkg::MAX_REPEAT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rbc_pkg::BYTE_W-1:0] data_in,
  input  logic                       end_of_stream,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rbc_pkg::BYTE_W-1:0] code_byte,
  output logic                       is_header,
  output logic                       last_of_run
);

  rbc_pkg::ctrl_cmd_t    cmd;
  rbc_pkg::ctrl_status_t status;

  rbc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  rbc_dpath #(
    .MAX_LITERAL(MAX_LITERAL),
    .MAX_REPEAT (MAX_REPEAT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .data_in      (data_in),
    .end_of_stream(end_of_stream),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_byte    (code_byte),
    .is_header    (is_header),
    .last_of_run  (last_of_run)
  );

endmodule

@@ sv/rbc_ram.sv @@
// rbc_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module rbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/rbc_dpath.sv @@
// rbc_dpath: datapath of the compressor: held byte, repeat count, literal
// buffer (rbc_ram) and the output register. Depends on rbc_pkg, rbc_ram.
`timescale 1ns / 1ps

module rbc_dpath #(
  parameter int MAX_LITERAL = rbc_pkg::MAX_LITERAL_DEF,
  parameter int MAX_REPEAT  = rbc_pkg::MAX_REPEAT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rbc_pkg::BYTE_W-1:0] data_in,
  input  logic                      end_of_stream,
  input  rbc_pkg::ctrl_cmd_t        cmd,
  output rbc_pkg::ctrl_status_t     status,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rbc_pkg::BYTE_W-1:0] code_byte,
  output logic                      is_header,
  output logic                      last_of_run
);

  localparam int AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
  localparam int CW = $clog2(MAX_LITERAL + 1);
  localparam int BW = rbc_pkg::BYTE_W;
  localparam int RW = rbc_pkg::RC_W;

  logic [BW-1:0] din;
  logic          eos;
  logic [BW-1:0] held, held_next;
  logic          have_held, have_held_next;
  logic [RW-1:0] rc, rc_next;
  logic [CW-1:0] lit_count, lit_count_next;
  logic [AW-1:0] idx, idx_next;
  logic [BW-1:0] lit_rdata;
  logic [RW-1:0] rc_m1;
  logic [BW-1:0] emit_byte;
  logic          emit_hdr;

  rbc_ram #(
    .WIDTH(BW),
    .DEPTH(MAX_LITERAL)
  ) u_lit_ram (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(lit_count[AW-1:0]),
    .wdata(held),
    .raddr(idx_next),
    .rdata(lit_rdata)
  );

  always_comb begin
    held_next      = held;
    have_held_next = have_held;
    rc_next        = rc;
    lit_count_next = lit_count;
    idx_next       = idx;
    if (cmd.first_load) begin
      held_next      = din;
      rc_next        = RW'(1);
      have_held_next = 1'b1;
    end
    if (cmd.set_rc2) begin
      rc_next = RW'(2);
    end
    if (cmd.inc_rc) begin
      rc_next = rc + RW'(1);
    end
    if (cmd.push) begin
      lit_count_next = lit_count + CW'(1);
    end
    if (cmd.load_new) begin
      held_next = din;
      rc_next   = RW'(1);
    end
    if (cmd.clear_all) begin
      held_next      = '0;
      have_held_next = 1'b0;
      rc_next        = '0;
    end
    if (cmd.lit_advance) begin
      idx_next = idx + AW'(1);
    end
    if (cmd.lit_done) begin
      idx_next       = '0;
      lit_count_next = '0;
    end
  end

  assign rc_m1 = rc - RW'(1);

  always_comb begin
    case (cmd.emit_sel)
      rbc_pkg::SEL_LIT_HDR: begin
        emit_byte = BW'(lit_count) - BW'(1);
        emit_hdr  = 1'b1;
      end
      rbc_pkg::SEL_RUN_HDR: begin
        emit_byte = {1'b1, rc_m1[6:0]};
        emit_hdr  = 1'b1;
      end
      rbc_pkg::SEL_LIT_DATA: begin
        emit_byte = lit_rdata;
        emit_hdr  = 1'b0;
      end
      default: begin
        emit_byte = held;
        emit_hdr  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      din <= data_in;
      eos <= end_of_stream;
    end
    if (cmd.emit) begin
      code_byte   <= emit_byte;
      is_header   <= emit_hdr;
      last_of_run <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      have_held <= 1'b0;
      rc        <= '0;
      lit_count <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      held      <= held_next;
      have_held <= have_held_next;
      rc        <= rc_next;
      lit_count <= lit_count_next;
      idx       <= idx_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.have_held     = have_held;
    status.eq            = (din == held);
    status.rc_is1        = (rc == RW'(1));
    status.rc_ge2        = (rc >= RW'(2));
    status.rc_at_max     = (rc >= RW'(MAX_REPEAT));
    status.lit_nz        = (lit_count != '0);
    status.lit_will_fill = (lit_count == CW'(MAX_LITERAL - 1));
    status.lit_last      = ((CW'(idx) + CW'(1)) == lit_count);
    status.eos           = eos;
    status.out_free      = !out_valid || out_ready;
  end

  a_lit_bound: assert property (@(posedge clk) disable iff (rst)
    lit_count <= CW'(MAX_LITERAL))
    else $error("literal count beyond buffer depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten before taken");

  a_held_count: assert property (@(posedge clk) disable iff (rst)
    have_held == (rc != '0))
    else $error("held flag and repeat count disagree");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (lit_count < CW'(MAX_LITERAL)))
    else $error("push into full literal buffer");

endmodule

@@ sv/rbc_ctrl.sv @@
// rbc_ctrl: controller state machine; sequences input beats, literal and
// run flushes, and the end-of-stream drain. Depends on rbc_pkg.
`timescale 1ns / 1ps

module rbc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rbc_pkg::ctrl_status_t status,
  output rbc_pkg::ctrl_cmd_t    cmd
);

  rbc_pkg::state_t state, state_next;
  logic            eos_phase, eos_phase_next;
  rbc_pkg::state_t after_main;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rbc_pkg::S_IDLE;
      eos_phase <= 1'b0;
    end else begin
      state     <= state_next;
      eos_phase <= eos_phase_next;
    end
  end

  // once the byte itself is handled, only end of stream has more to do
  assign after_main = status.eos ? rbc_pkg::S_EOS_CHK : rbc_pkg::S_IDLE;

  always_comb begin
    state_next     = state;
    eos_phase_next = eos_phase;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.emit_sel   = rbc_pkg::SEL_HELD;
    case (state)
      rbc_pkg::S_IDLE: begin
        // no beat is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.latch_in   = 1'b1;
          eos_phase_next = 1'b0;
          state_next     = rbc_pkg::S_EVAL;
        end
      end
      rbc_pkg::S_EVAL: begin
        if (!status.have_held) begin
          cmd.first_load = 1'b1;
          state_next     = after_main;
        end else if (status.eq) begin
          if (status.rc_is1) begin
            cmd.set_rc2 = 1'b1;
            state_next  = status.lit_nz ? rbc_pkg::S_LIT_HDR : after_main;
          end else if (!status.rc_at_max) begin
            cmd.inc_rc = 1'b1;
            state_next = after_main;
          end else begin
            state_next = rbc_pkg::S_RUN_HDR;
          end
        end else if (status.rc_ge2) begin
          state_next = rbc_pkg::S_RUN_HDR;
        end else begin
          cmd.push     = 1'b1;
          cmd.load_new = 1'b1;
          state_next   = status.lit_will_fill ? rbc_pkg::S_LIT_HDR : after_main;
        end
      end
      rbc_pkg::S_EOS_CHK: begin
        eos_phase_next = 1'b1;
        if (status.rc_is1) begin
          cmd.push   = 1'b1;
          state_next = rbc_pkg::S_LIT_HDR;
        end else begin
          state_next = status.lit_nz ? rbc_pkg::S_LIT_HDR : rbc_pkg::S_RUN_HDR;
        end
      end
      rbc_pkg::S_LIT_HDR: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rbc_pkg::SEL_LIT_HDR;
          state_next   = rbc_pkg::S_LIT_DATA;
        end
      end
      rbc_pkg::S_LIT_DATA: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rbc_pkg::SEL_LIT_DATA;
          if (status.lit_last) begin
            cmd.lit_done  = 1'b1;
            cmd.emit_last = eos_phase ? !status.rc_ge2 : !status.eos;
            if (!eos_phase) begin
              state_next = after_main;
            end else if (status.rc_ge2) begin
              state_next = rbc_pkg::S_RUN_HDR;
            end else begin
              cmd.clear_all = 1'b1;
              state_next    = rbc_pkg::S_IDLE;
            end
          end else begin
            cmd.lit_advance = 1'b1;
          end
        end
      end
      rbc_pkg::S_RUN_HDR: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rbc_pkg::SEL_RUN_HDR;
          state_next   = rbc_pkg::S_RUN_BYTE;
        end
      end
      rbc_pkg::S_RUN_BYTE: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rbc_pkg::SEL_HELD;
          if (eos_phase) begin
            cmd.emit_last = 1'b1;
            cmd.clear_all = 1'b1;
            state_next    = rbc_pkg::S_IDLE;
          end else begin
            cmd.emit_last = !status.eos;
            cmd.load_new  = 1'b1;
            state_next    = after_main;
          end
        end
      end
      default: begin
        state_next = rbc_pkg::S_IDLE;
      end
    endcase
  end

  // a run only starts after pending literals went out
  a_run_no_lits: assert property (@(posedge clk) disable iff (rst)
    (state == rbc_pkg::S_IDLE) |-> !(status.rc_ge2 && status.lit_nz))
    else $error("run open with literals pending");

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == rbc_pkg::S_EVAL))
    else $error("accepted beat not evaluated");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == rbc_pkg::S_IDLE && eos_phase) |-> !status.have_held)
    else $error("state left after end of stream");

endmodule

@@ tb/rle_byte_compressor_tb.sv @@
// rle_byte_compressor_tb: self-checking bench for the PackBits-style byte compressor.
// Drives raw byte beats in bursts, predicts the code beats and checks them in order.
// Depends on rbc_pkg and rle_byte_compressor.
`timescale 1ns / 1ps

module rle_byte_compressor_tb;

  localparam int BYTE_W       = rbc_pkg::BYTE_W;
  localparam int LIT_MAX      = rbc_pkg::MAX_LITERAL_DEF;
  localparam int RUN_MAX      = rbc_pkg::MAX_REPEAT_DEF;
  localparam logic [7:0] RUN_HDR_BASE = 8'd128;
  localparam logic [7:0] RUN_LEN_MASK = 8'd127;
  localparam int RAND_ITEMS   = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eos;
  } raw_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              hdr;
    logic              last;
  } code_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] data_in = '0;
  logic              end_of_stream = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] code_byte;
  logic              is_header;
  logic              last_of_run;

  raw_beat_t  raw_q[$];
  code_beat_t code_q[$];
  code_beat_t step_out[$];

  int errors = 0;
  int cyc    = 0;
  int gen_count;

  // encoder shadow state
  logic [BYTE_W-1:0] lit_buf [0:LIT_MAX-1];
  int                lit_cnt = 0;
  logic [BYTE_W-1:0] held = '0;
  bit                held_ok = 1'b0;
  int                rep_cnt = 0;

  // sender burst control
  int burst_left = 0;
  int gap_left   = 0;

  rle_byte_compressor dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_in      (data_in),
    .end_of_stream(end_of_stream),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_byte    (code_byte),
    .is_header    (is_header),
    .last_of_run  (last_of_run)
  );

  always #10 clk = ~clk;

  // ---------------- prediction ----------------

  task automatic put_code(input logic [BYTE_W-1:0] b, input logic hdr);
    code_beat_t c;
    c.code = b;
    c.hdr  = hdr;
    c.last = 1'b0;
    step_out.push_back(c);
  endtask

  task automatic flush_lits();
    if (lit_cnt != 0) begin
      put_code(8'(lit_cnt - 1), 1'b1);
      for (int k = 0; k < lit_cnt; k++) put_code(lit_buf[k], 1'b0);
      lit_cnt = 0;
    end
  endtask

  task automatic flush_rep();
    put_code(RUN_HDR_BASE + (8'(rep_cnt - 1) & RUN_LEN_MASK), 1'b1);
    put_code(held, 1'b0);
  endtask

  task automatic push_lit(input logic [BYTE_W-1:0] b);
    if (lit_cnt < LIT_MAX) begin
      lit_buf[lit_cnt] = b;
      lit_cnt++;
    end
    if (lit_cnt >= LIT_MAX) flush_lits();
  endtask

  task automatic encode_byte(input logic [BYTE_W-1:0] d, input logic eos);
    code_beat_t c;
    step_out.delete();
    if (!held_ok) begin
      held    = d;
      rep_cnt = 1;
      held_ok = 1'b1;
    end else if (d == held) begin
      if (rep_cnt <= 1) begin
        flush_lits();
        rep_cnt = 2;
      end else if (rep_cnt < RUN_MAX) begin
        rep_cnt++;
      end else begin
        flush_rep();
        rep_cnt = 1;
      end
    end else begin
      if (rep_cnt >= 2) flush_rep();
      else push_lit(held);
      held    = d;
      rep_cnt = 1;
    end
    if (eos) begin
      if (rep_cnt == 1) push_lit(held);
      flush_lits();
      if (rep_cnt >= 2) flush_rep();
      held_ok = 1'b0;
      rep_cnt = 0;
      held    = '0;
    end
    if (step_out.size() > 0) begin
      c = step_out.pop_back();
      c.last = 1'b1;
      step_out.push_back(c);
    end
    while (step_out.size() > 0) code_q.push_back(step_out.pop_front());
  endtask

  // ---------------- stimulus generation ----------------

  task automatic add_beat(input logic [BYTE_W-1:0] d, input logic eos);
    raw_beat_t r;
    r.data = d;
    r.eos  = eos;
    raw_q.push_back(r);
    gen_count++;
  endtask

  function automatic logic [BYTE_W-1:0] other_byte(input logic [BYTE_W-1:0] prev);
    return prev + 8'($urandom_range(1, 255));
  endfunction

  task automatic add_run(inout logic [BYTE_W-1:0] prev, input int len);
    logic [BYTE_W-1:0] b;
    b = other_byte(prev);
    for (int i = 0; i < len; i++) add_beat(b, 1'b0);
    prev = b;
  endtask

  task automatic add_literal(inout logic [BYTE_W-1:0] prev, input int len);
    for (int i = 0; i < len; i++) begin
      prev = other_byte(prev);
      add_beat(prev, 1'b0);
    end
  endtask

  task automatic add_stream(input bit force_long);
    logic [BYTE_W-1:0] prev;
    raw_beat_t         r;
    int                nseg;
    int                kind;
    int                len;
    prev = 8'($urandom);
    if (force_long) begin
      // full run plus one more copy, then one byte past a full literal buffer
      add_run(prev, RUN_MAX + 1);
      add_literal(prev, LIT_MAX + 1);
    end
    nseg = $urandom_range(1, 6);
    for (int s = 0; s < nseg; s++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(RUN_MAX - 2, RUN_MAX + 2)
                                           : $urandom_range(2, 8);
        add_run(prev, len);
      end else if (kind <= 7) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(LIT_MAX - 2, LIT_MAX + 8)
                                          : $urandom_range(1, 8);
        add_literal(prev, len);
      end else begin
        // noise: small alphabet makes accidental pairs and stray stream ends
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          prev = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
          add_beat(prev, ($urandom_range(0, 30) == 0));
        end
      end
    end
    // most streams close with an end mark; some run on into the next one
    if ($urandom_range(0, 5) != 0) begin
      r = raw_q.pop_back();
      r.eos = 1'b1;
      raw_q.push_back(r);
    end
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin : driver
    raw_beat_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r = raw_q.pop_front();
        encode_byte(r.data, r.eos);
      end
      if (in_valid && !in_ready) begin
        // hold the beat until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (raw_q.size() > 0) begin
        in_valid      <= 1'b1;
        data_in       <= raw_q[0].data;
        end_of_stream <= raw_q[0].eos;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
          gap_left   = $urandom_range(0, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin : monitor
    code_beat_t want;
    code_beat_t got;
    cyc++;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.code = code_byte;
        got.hdr  = is_header;
        got.last = last_of_run;
        if (code_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual code=%02h hdr=%b last=%b",
                   $time, got.code, got.hdr, got.last);
          errors++;
        end else begin
          want = code_q.pop_front();
          if (got.code !== want.code || got.hdr !== want.hdr || got.last !== want.last) begin
            $display("%0t: mismatch expected code=%02h hdr=%b last=%b,",
                     $time, want.code, want.hdr, want.last,
                     " actual code=%02h hdr=%b last=%b",
                     got.code, got.hdr, got.last);
            errors++;
          end
        end
      end
      // receiver stall modes rotate: always ready, coin flip, fixed duty pattern
      case ((cyc / 300) % 3)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ((cyc % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cyc >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    gen_count = 0;
    // directed: byte extremes, pairs, literals cut by a pair, end-of-stream flushes
    add_beat(8'h00, 1'b1);
    add_beat(8'hFF, 1'b1);
    add_beat(8'hAA, 1'b0);
    add_beat(8'hAA, 1'b1);
    add_beat(8'h01, 1'b0);
    add_beat(8'h02, 1'b0);
    add_beat(8'h03, 1'b0);
    add_beat(8'h03, 1'b0);
    add_beat(8'h03, 1'b1);
    add_beat(8'h10, 1'b0);
    add_beat(8'h20, 1'b1);
    add_beat(8'h55, 1'b0);
    add_beat(8'h55, 1'b0);
    add_beat(8'h66, 1'b1);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h7F, 1'b0);
    add_beat(8'h80, 1'b1);
    gen_count = 0;
    add_stream(1'b1);
    while (gen_count < RAND_ITEMS) add_stream(1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (raw_q.size() != 0 || in_valid || code_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && code_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
